// ----- design/ensemble_predicate_count_fuzzy_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ensemble predicate counter
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ENSEMBLE_PREDICATE_COUNT_FUZZY_ASSERT_SVH
`define ENSEMBLE_PREDICATE_COUNT_FUZZY_ASSERT_SVH

// condition holds at every edge
`define EPCF_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define EPCF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define EPCF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/epcf_pkg.sv -----
// ----------------------------------------------------------------------------
// epcf_pkg
// Shared types and constants of the ensemble predicate counter.
// ----------------------------------------------------------------------------
`default_nettype none

package epcf_pkg;

  localparam int MAX_MEMBERS = 64;
  localparam int CNT_W       = 7;
  localparam int VAL_W       = 32;
  localparam int MODE_W      = 3;
  localparam int MEMB_W      = 17;
  localparam int QUOT_W      = 16;
  localparam logic [MEMB_W-1:0] ONE_Q16 = MEMB_W'(65536);

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int LVL_W  = $clog2(QDEPTH + 1);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_VALUE = 2'd1;
  localparam logic [1:0] REG_LOW   = 2'd2;
  localparam logic [1:0] REG_HIGH  = 2'd3;

  // compare operators
  localparam logic [MODE_W-1:0] CMP_GT = 3'd0;
  localparam logic [MODE_W-1:0] CMP_GE = 3'd1;
  localparam logic [MODE_W-1:0] CMP_LT = 3'd2;
  localparam logic [MODE_W-1:0] CMP_LE = 3'd3;
  localparam logic [MODE_W-1:0] CMP_EQ = 3'd4;
  localparam logic [MODE_W-1:0] CMP_NE = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        low;
    logic [CNT_W-1:0]        high;
  } cfg_t;

  // one finished point: count plus bounds in force at its end
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] low;
    logic [CNT_W-1:0] high;
  } point_t;

endpackage

`default_nettype wire

// ----- design/ensemble_predicate_count_fuzzy.sv -----
// ----------------------------------------------------------------------------
// ensemble_predicate_count_fuzzy
// Counts members of each grid point that pass a threshold test and emits
// the count with a fuzzy membership value in Q1.16.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | tdata member_value, tlast last_member
//  m_*      | out | m_tvalid/m_tready  | tdata membership, pass_count
//  apb      | in  | psel/penable/pwrite| 4 regs at 4*i, pready always high
//
//  Members are taken one per cycle while the point queue has room.
//  Each point then goes through the divider (one quotient bit per
//  cycle), unless the bounds settle the result directly.
//  A four-entry point queue lets counting run ahead of the divider.
//  Synchronous reset clears registers, count, queue and divider state.
// ----------------------------------------------------------------------------
`default_nettype none

module ensemble_predicate_count_fuzzy
  import epcf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [VAL_W-1:0]         s_tdata,   // [31:0] member_value
  input  wire logic                     s_tlast,   // last_member
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [MEMB_W+CNT_W-1:0]       m_tdata,   // [16:0] membership, [23:17] pass_count
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ADDR_W-1:0]        paddr,
  input  wire logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  cfg_t   cfg;
  logic   cfg_wr;
  logic   q_full;
  logic   q_valid;
  logic   push;
  logic   pop;
  point_t push_data;
  point_t q_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode  <= '0;
      cfg.value <= '0;
      cfg.low   <= '0;
      cfg.high  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MODE:  cfg.mode  <= pwdata[MODE_W-1:0];
        REG_VALUE: cfg.value <= $signed(pwdata[VAL_W-1:0]);
        REG_LOW:   cfg.low   <= pwdata[CNT_W-1:0];
        REG_HIGH:  cfg.high  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:  prdata = DATA_W'(cfg.mode);
      REG_VALUE: prdata = DATA_W'(cfg.value);
      REG_LOW:   prdata = DATA_W'(cfg.low);
      REG_HIGH:  prdata = DATA_W'(cfg.high);
      default:   prdata = '0;
    endcase
  end

  epcf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   ($signed(s_tdata)),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  epcf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_data),
    .pop   (pop),
    .full  (q_full),
    .valid (q_valid),
    .dout  (q_data)
  );

  epcf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

// ----- design/epcf_front.sv -----
// ----------------------------------------------------------------------------
// epcf_front
// Compares each member against the threshold and counts passes; pushes
// the finished point into the queue on the last member.
// ----------------------------------------------------------------------------
`default_nettype none

module epcf_front
  import epcf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cfg_t                    cfg,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic signed [VAL_W-1:0] s_tdata,   // member_value
  input  wire logic                    s_tlast,   // last_member
  input  wire logic                    q_full,
  output logic                         push,
  output point_t                       push_data
);

  `include "ensemble_predicate_count_fuzzy_assert.svh"

  logic [CNT_W-1:0] running_count;
  logic [CNT_W-1:0] count_next;
  logic             passes;
  logic             accept;

  always_comb begin
    case (cfg.mode)
      CMP_GT:  passes = s_tdata >  cfg.value;
      CMP_GE:  passes = s_tdata >= cfg.value;
      CMP_LT:  passes = s_tdata <  cfg.value;
      CMP_LE:  passes = s_tdata <= cfg.value;
      CMP_EQ:  passes = s_tdata == cfg.value;
      CMP_NE:  passes = s_tdata != cfg.value;
      default: passes = 1'b0;
    endcase
  end

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign count_next = (passes && (running_count < CNT_W'(MAX_MEMBERS))) ?
                      running_count + 1'b1 : running_count;

  assign push            = accept && s_tlast;
  assign push_data.count = count_next;
  assign push_data.low   = cfg.low;
  assign push_data.high  = cfg.high;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_count <= '0;
    end else if (accept) begin
      running_count <= s_tlast ? '0 : count_next;
    end
  end

  `EPCF_ASSERT_IMP(a_no_push_full, q_full, !push, "point pushed into full queue")

endmodule

`default_nettype wire

// ----- design/epcf_queue.sv -----
// ----------------------------------------------------------------------------
// epcf_queue
// Short FIFO of finished points between counter and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module epcf_queue
  import epcf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire point_t din,
  input  wire logic   pop,
  output logic        full,
  output logic        valid,
  output point_t      dout
);

  `include "ensemble_predicate_count_fuzzy_assert.svh"

  point_t            entries [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [LVL_W-1:0]  level;
  logic              do_push;
  logic              do_pop;

  assign full    = (level == LVL_W'(QDEPTH));
  assign valid   = (level != '0);
  assign dout    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

  `EPCF_ASSERT_ALWAYS(a_level_range, level <= LVL_W'(QDEPTH), "queue level past depth")

endmodule

`default_nettype wire

// ----- design/epcf_back.sv -----
// ----------------------------------------------------------------------------
// epcf_back
// Takes finished points, works out the clamped membership ratio with a
// one-bit-per-cycle restoring divider, and holds the result for transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module epcf_back
  import epcf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_valid,
  input  wire point_t q_data,
  output logic        pop,
  output logic        m_tvalid,
  input  wire logic   m_tready,
  output logic [MEMB_W+CNT_W-1:0] m_tdata   // membership, pass_count
);

  `include "ensemble_predicate_count_fuzzy_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic [MEMB_W-1:0]      result;
  logic [CNT_W:0]         divisor;
  logic [CNT_W:0]         rem;
  logic [QUOT_W-1:0]      numer;
  logic [QUOT_W-1:0]      quot;
  logic [3:0]             step;

  logic                   out_valid;
  logic [MEMB_W-1:0]      out_memb;
  logic [CNT_W-1:0]       out_count;

  logic signed [CNT_W:0]  d;
  logic signed [CNT_W:0]  r;
  logic [CNT_W-1:0]       ad;
  logic [CNT_W-1:0]       ar;
  logic [CNT_W+1:0]       trial;
  logic                   qbit;
  logic                   out_free;

  assign d  = $signed({1'b0, q_data.count}) - $signed({1'b0, q_data.low});
  assign r  = $signed({1'b0, q_data.high}) - $signed({1'b0, q_data.low});
  assign ad = d[CNT_W] ? CNT_W'(-d) : d[CNT_W-1:0];
  assign ar = r[CNT_W] ? CNT_W'(-r) : r[CNT_W-1:0];

  assign trial = {rem, numer[QUOT_W-1]};
  assign qbit  = (trial >= {1'b0, divisor});

  assign pop      = (state == S_IDLE) && q_valid;
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            count <= q_data.count;
            if (r == '0) begin
              result <= (d > 0) ? ONE_Q16 : '0;
              state  <= S_DONE;
            end else if ((d == '0) || (d[CNT_W] != r[CNT_W])) begin
              result <= '0;
              state  <= S_DONE;
            end else if (ad >= ar) begin
              result <= ONE_Q16;
              state  <= S_DONE;
            end else begin
              // (2*ad*2^16 + ar) / (2*ar); top part 2*ad is below divisor
              rem     <= {ad, 1'b0};
              divisor <= {ar, 1'b0};
              numer   <= QUOT_W'(ar);
              quot    <= '0;
              step    <= 4'(QUOT_W - 1);
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem   <= qbit ? (CNT_W+1)'(trial - {1'b0, divisor}) : trial[CNT_W:0];
          numer <= {numer[QUOT_W-2:0], 1'b0};
          quot  <= {quot[QUOT_W-2:0], qbit};
          if (step == '0) begin
            result <= {1'b0, quot[QUOT_W-2:0], qbit};
            state  <= S_DONE;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_memb  <= result;
      out_count <= count;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_count, out_memb};

  `EPCF_ASSERT_NEXT(a_load_out, (state == S_DONE) && out_free, m_tvalid, "result not loaded")
  `EPCF_ASSERT_IMP(a_memb_range, out_valid, out_memb <= ONE_Q16, "membership above one")
  `EPCF_ASSERT_IMP(a_pop_idle, pop, state == S_IDLE, "point taken while busy")

endmodule

`default_nettype wire

// ----- sim/epcf_checker.sv -----
// ----------------------------------------------------------------------------
// epcf_checker
// Watches the member stream, the result stream and the register port of the
// ensemble predicate counter. Keeps its own copy of the registers and the
// running pass count, predicts each point's pass count and fuzzy membership,
// and compares every result transfer and register read against it.
// ----------------------------------------------------------------------------
module epcf_checker
  import epcf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  input  wire logic                    s_tready,
  input  wire logic [VAL_W-1:0]        s_tdata,   // [31:0] member_value
  input  wire logic                    s_tlast,   // last_member
  input  wire logic                    m_tvalid,
  input  wire logic                    m_tready,
  input  wire logic [MEMB_W+CNT_W-1:0] m_tdata,   // [16:0] membership, [23:17] pass_count
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ADDR_W-1:0]       paddr,
  input  wire logic [DATA_W-1:0]       pwdata,
  input  wire logic [DATA_W-1:0]       prdata,
  input  wire logic                    pready,
  output int                           fail_count,
  output int                           results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [MEMB_W-1:0] membership;
    logic [CNT_W-1:0]  count;
  } point_result_t;

  cfg_t             settings;
  logic [CNT_W-1:0] pass_run;
  point_result_t    expected_points[$];
  int               fails = 0;

  function automatic logic passes_threshold(logic signed [VAL_W-1:0] v, cfg_t c);
    logic signed [VAL_W-1:0] thr;
    thr = $signed(c.value);
    case (c.mode)
      CMP_GT:  return v > thr;
      CMP_GE:  return v >= thr;
      CMP_LT:  return v < thr;
      CMP_LE:  return v <= thr;
      CMP_EQ:  return v == thr;
      CMP_NE:  return v != thr;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [MEMB_W-1:0] membership_of(logic [CNT_W-1:0] n, cfg_t c);
    longint d, r, ad, ar;
    d = n;
    d = d - c.low;
    r = c.high;
    r = r - c.low;
    if (r == 0) return (d > 0) ? ONE_Q16 : '0;
    if (d == 0 || ((d > 0) != (r > 0))) return '0;
    ad = (d < 0) ? -d : d;
    ar = (r < 0) ? -r : r;
    if (ad >= ar) return ONE_Q16;
    return MEMB_W'((ad * 2 * 65536 + ar) / (2 * ar));
  endfunction

  function automatic logic [DATA_W-1:0] reg_value(logic [1:0] idx, cfg_t c);
    case (idx)
      REG_MODE:  return DATA_W'(c.mode);
      REG_VALUE: return DATA_W'(c.value);
      REG_LOW:   return DATA_W'(c.low);
      default:   return DATA_W'(c.high);
    endcase
  endfunction

  always @(posedge clk) begin : watch
    point_result_t want;
    logic [1:0]    idx;
    idx = paddr[ADDR_W-1:2];
    if (rst) begin
      settings = '0;
      pass_run = '0;
      expected_points.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_points.size() == 0) begin
          $error("result with none expected: membership %0d, pass_count %0d",
                 m_tdata[MEMB_W-1:0], m_tdata[MEMB_W+:CNT_W]);
          fails++;
        end else begin
          want = expected_points.pop_front();
          if (m_tdata[MEMB_W-1:0] !== want.membership) begin
            $error("membership: expected %0d, actual %0d", want.membership,
                   m_tdata[MEMB_W-1:0]);
            fails++;
          end
          if (m_tdata[MEMB_W+:CNT_W] !== want.count) begin
            $error("pass_count: expected %0d, actual %0d", want.count,
                   m_tdata[MEMB_W+:CNT_W]);
            fails++;
          end
        end
      end

      if (s_tvalid && s_tready) begin
        if (passes_threshold(s_tdata, settings) && pass_run < MAX_MEMBERS) pass_run++;
        if (s_tlast) begin
          want.count      = pass_run;
          want.membership = membership_of(pass_run, settings);
          expected_points.insert(expected_points.size(), want);
          pass_run = '0;
        end
      end

      if (psel && penable && pready) begin
        if (pwrite) begin
          case (idx)
            REG_MODE:  settings.mode  = pwdata[MODE_W-1:0];
            REG_VALUE: settings.value = pwdata[VAL_W-1:0];
            REG_LOW:   settings.low   = pwdata[CNT_W-1:0];
            default:   settings.high  = pwdata[CNT_W-1:0];
          endcase
        end else if (prdata !== reg_value(idx, settings)) begin
          $error("prdata[%0d]: expected %0h, actual %0h", idx, reg_value(idx, settings),
                 prdata);
          fails++;
        end
      end
    end
    fail_count      <= fails;
    results_pending <= expected_points.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives member points into the ensemble predicate counter under a range of
// compare operators, thresholds and ramp bounds, with bursty input, a
// stalling result side and register writes between phases. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import epcf_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 150;
  localparam int RANDOM_PHASES = 11;
  localparam int PRESSURE_PHASE = 4;

  logic                    clk      = 1'b0;
  logic                    rst      = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [VAL_W-1:0]        s_tdata  = '0;   // [31:0] member_value
  logic                    s_tlast  = 1'b0; // last_member
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [MEMB_W+CNT_W-1:0] m_tdata;         // [16:0] membership, [23:17] pass_count
  logic                    psel     = 1'b0;
  logic                    penable  = 1'b0;
  logic                    pwrite   = 1'b0;
  logic [ADDR_W-1:0]       paddr    = '0;
  logic [DATA_W-1:0]       pwdata   = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  int fail_count;
  int results_pending;

  int idle_cycles  = 0;
  int hold_trigger = 0;
  int burst_left   = 0;
  bit gaps_on      = 1'b1;
  int members_sent = 0;
  logic [VAL_W-1:0] cur_thr = '0;

  always #6 clk = ~clk;

  ensemble_predicate_count_fuzzy uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  epcf_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .results_pending(results_pending)
  );

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[ensemble_predicate_count_fuzzy] ERROR");
      $finish;
    end
  end

  // result-side stall pattern, with a long hold-off on request
  always @(posedge clk) begin : rx_pattern
    static int hold_taken = 0;
    static int hold_left  = 0;
    static int seg_left   = 0;
    static int rx_mode    = 0;
    bit ready_next;
    if (hold_trigger != hold_taken) begin
      hold_taken = hold_trigger;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(200, 20);
        rx_mode  = $urandom_range(3, 0);
      end
      seg_left--;
      case (rx_mode)
        0:       ready_next = 1'b1;
        1:       ready_next = 1'($urandom_range(1, 0));
        2:       ready_next = ($urandom_range(3, 0) == 0);
        default: ready_next = (seg_left % 5) != 0;
      endcase
    end
    m_tready <= ready_next;
  end

  task automatic push_member(input logic [VAL_W-1:0] v, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(30, 1);
      gap = gaps_on ? $urandom_range(6, 0) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    members_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [MODE_W-1:0] mode, input logic [VAL_W-1:0] thr,
                            input logic [CNT_W-1:0] low, input logic [CNT_W-1:0] high);
    apb_access(1'b1, REG_MODE, DATA_W'(mode));
    apb_access(1'b1, REG_VALUE, DATA_W'(thr));
    apb_access(1'b1, REG_LOW, DATA_W'(low));
    apb_access(1'b1, REG_HIGH, DATA_W'(high));
    apb_access(1'b0, REG_MODE, '0);
    apb_access(1'b0, REG_VALUE, '0);
    apb_access(1'b0, REG_LOW, '0);
    apb_access(1'b0, REG_HIGH, '0);
    cur_thr = thr;
  endtask

  function automatic logic [VAL_W-1:0] pick_member(logic [VAL_W-1:0] thr);
    case ($urandom_range(9, 0))
      0, 1:    return thr;
      2:       return thr + 1;
      3:       return thr - 1;
      4:       return 32'h8000_0000;
      5:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_bound();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return CNT_W'(MAX_MEMBERS);
      2:       return CNT_W'($urandom_range(MAX_MEMBERS, 0));
      default: return CNT_W'($urandom_range(12, 0));
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_threshold();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return $urandom_range(32'h0004_0000, 0) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_point(input int len);
    for (int k = 0; k < len; k++) push_member(pick_member(cur_thr), k == len - 1);
  endtask

  task automatic random_config();
    logic [CNT_W-1:0] low;
    logic [CNT_W-1:0] high;
    low  = pick_bound();
    high = ($urandom_range(3, 0) == 0) ? low : pick_bound();
    set_config(MODE_W'($urandom_range(7, 0)), pick_threshold(), low, high);
  endtask

  function automatic int pick_length();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 3) return $urandom_range(80, 60);
    if (roll < 20) return $urandom_range(20, 9);
    return $urandom_range(8, 1);
  endfunction

  initial begin : stimulus
    int phase_start;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: greater than zero, both bounds zero
    push_member(32'd1, 1'b0);
    push_member(32'hFFFF_FFFF, 1'b0);
    push_member(32'd0, 1'b1);
    push_member(32'd0, 1'b1);
    drain();

    set_config(CMP_GE, 32'h7FFF_FFFF, 7'd0, 7'd2);
    push_member(32'h7FFF_FFFF, 1'b0);
    push_member(32'h8000_0000, 1'b1);
    drain();
    set_config(CMP_LT, 32'h8000_0000, 7'd0, 7'd64);
    push_member(32'h8000_0000, 1'b1);
    drain();
    set_config(CMP_LE, 32'd0, 7'd1, 7'd4);
    push_member(32'hFFFF_FFFF, 1'b0);
    push_member(32'h0001_0000, 1'b0);
    push_member(32'd0, 1'b1);
    drain();
    set_config(CMP_EQ, 32'h1234_5678, 7'd2, 7'd2);
    push_member(32'h1234_5678, 1'b0);
    push_member(32'h1234_5679, 1'b0);
    push_member(32'h1234_5678, 1'b1);
    drain();
    set_config(CMP_NE, 32'h1234_5678, 7'd64, 7'd0);
    push_member(32'h1234_5678, 1'b0);
    push_member(32'hAAAA_AAAA, 1'b1);
    drain();
    // unused operator codes never pass
    set_config(MODE_W'(6), 32'd0, 7'd0, 7'd1);
    push_member(32'd0, 1'b0);
    push_member(32'd5, 1'b1);
    drain();
    set_config(MODE_W'(7), 32'd0, 7'd0, 7'd1);
    push_member(32'h5555_5555, 1'b1);
    drain();
    // reversed bounds: membership falls as the count rises
    set_config(CMP_GE, 32'h8000_0000, 7'd3, 7'd1);
    push_member(32'd9, 1'b0);
    push_member(32'hF000_0000, 1'b1);
    push_member(32'h8000_0000, 1'b1);
    drain();
    // register change in the middle of a point keeps the partial count
    set_config(CMP_GT, 32'd0, 7'd0, 7'd3);
    push_member(32'd5, 1'b0);
    push_member(-32'sd5, 1'b0);
    drain();
    set_config(CMP_LT, 32'd0, 7'd0, 7'd3);
    push_member(-32'sd7, 1'b1);
    drain();

    // count saturation: every member passes
    set_config(CMP_GE, 32'h8000_0000, 7'd0, 7'd64);
    send_point(70);
    send_point(64);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_config();
      phase_start = members_sent;
      if (phase == PRESSURE_PHASE) begin
        gaps_on = 1'b0;
        hold_trigger <= hold_trigger + 1;
        for (int p = 0; p < 40; p++) send_point($urandom_range(3, 1));
      end else begin
        gaps_on = ($urandom_range(3, 0) != 0);
        while (members_sent - phase_start < PHASE_ITEMS) send_point(pick_length());
      end
      drain();
    end

    if (fail_count == 0 && results_pending == 0) begin
      $display("[ensemble_predicate_count_fuzzy] OK");
    end else begin
      $display("[ensemble_predicate_count_fuzzy] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/epcf_pkg.sv
design/epcf_front.sv
design/epcf_queue.sv
design/epcf_back.sv
design/ensemble_predicate_count_fuzzy.sv
sim/epcf_checker.sv
sim/tb_top.sv
